[rtl/spv_pkg.sv]
// Shared types and constants for the sample playback voice.
// Depends on nothing; imported by spv_regs and the voice top level.
package spv_pkg;

    // Default sizes of the voice
    localparam int DEF_SAMPLE_DEPTH = 65536;
    localparam int DEF_SAMPLE_BITS  = 16;
    localparam int DEF_FRAC_BITS    = 16;

    // Fixed field widths
    localparam int POS_BITS      = 33;
    localparam int CFG_ADDR_BITS = 5;
    localparam int GAIN_FRAC     = 12;   // 4.12 gain
    localparam int FADE_FRAC     = 16;   // 1.16 fade
    localparam logic [16:0] FADE_UNITY = 17'h10000;

    // Register indexes (paddr[4:2])
    localparam logic [2:0] REG_START_POS  = 3'd0;
    localparam logic [2:0] REG_STOP_FRAME = 3'd1;
    localparam logic [2:0] REG_COUNT      = 3'd2;
    localparam logic [2:0] REG_STEP       = 3'd3;
    localparam logic [2:0] REG_GAIN       = 3'd4;
    localparam logic [2:0] REG_REL_LEN    = 3'd5;
    localparam logic [2:0] REG_REL_RECIP  = 3'd6;

    // Register reset values
    localparam logic [31:0] RST_START_POS  = 32'd0;
    localparam logic [16:0] RST_STOP_FRAME = 17'd65536;
    localparam logic [16:0] RST_COUNT      = 17'd65536;
    localparam logic [23:0] RST_STEP       = 24'd65536;
    localparam logic [15:0] RST_GAIN       = 16'd4096;
    localparam logic [15:0] RST_REL_LEN    = 16'd480;
    localparam logic [16:0] RST_REL_RECIP  = 17'd137;

    typedef enum logic [1:0] {
        FN_WRITE   = 2'd0,
        FN_TICK    = 2'd1,
        FN_RELEASE = 2'd2,
        FN_RESTART = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_MUL,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic [31:0] play_start;
        logic [16:0] stop_frame;
        logic [16:0] sample_count;
        logic [23:0] playback_step;
        logic [15:0] linear_gain;
        logic [15:0] release_length;
        logic [16:0] release_recip;
    } cfg_t;

endpackage

[rtl/sample_playback_voice_interp_core.sv]
// Top level of the one-shot sample playback voice with linear interpolation.
// Depends on spv_pkg, spv_ram (sample store) and spv_regs (configuration).
//
// Usage:
//   s_* channel carries command words: s_tuser selects write sample, tick,
//   begin release or restart; s_tdata holds address and sample value.
//   m_* channel returns one word per tick: rendered sample and active flag.
//   Configuration goes through the APB-style port, written while idle.
// Sequencing:
//   Write, release and restart words return nothing.
//   A tick on a sounding voice runs two back-to-back reads of
//   the single-port sample RAM (lower, then upper neighbor), one stage for
//   the blend multiplies, one for the gain multiply, one to round and load
//   the output register. No new word is taken until the tick has loaded
//   its result. A tick on a silent voice, or one that hits the end frame,
//   skips the reads and multiplies.
// Reset: voice active at the start position, no release pending. The
//   sample RAM is not cleared; read only entries that were written.
// Stall: a result waits in the output register while m_tready is low; the
//   next word is still taken, but a following tick holds in its final step
//   (s_tready low) until the output register frees up.
module sample_playback_voice_interp_core
    import spv_pkg::*;
#(
    parameter int SAMPLE_DEPTH = DEF_SAMPLE_DEPTH,
    parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS,
    parameter int FRAC_BITS    = DEF_FRAC_BITS
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    // command channel
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [31:0]              s_tdata,  // [15:0] address, [31:16] sample_value
    input  logic [1:0]               s_tuser,  // [1:0] func
    // result channel
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [15:0]              m_tdata,  // [15:0] sample_out
    output logic [0:0]               m_tuser,  // [0] voice_active
    // configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready
);

    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int MW = SAMPLE_BITS + FRAC_BITS + 2;   // blended sample
    localparam int PW = MW + 17;                       // after gain
    localparam int SH = FRAC_BITS + GAIN_FRAC;
    localparam logic [FRAC_BITS:0] ONE_F = (FRAC_BITS+1)'(1) << FRAC_BITS;
    localparam logic [PW-1:0] HALF = PW'(1) << (SH - 1);
    localparam int SMAX = (1 << (SAMPLE_BITS - 1)) - 1;
    localparam int SMIN = -(1 << (SAMPLE_BITS - 1));

    cfg_t   cfg;
    func_t  s_func;
    state_t state_reg, state_next;
    logic   in_acc;

    // voice state
    logic [POS_BITS-1:0] pos_reg;
    logic                active_reg;
    logic                releasing_reg;
    logic [15:0]         rem_reg;

    // per-tick work registers
    logic [AW-1:0]          idx1_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic [16:0]            fade_reg;
    logic [15:0]            g_reg;
    logic [SAMPLE_BITS-1:0] s0_reg;
    logic signed [MW-1:0]   mix_reg;
    logic signed [PW-1:0]   prod_reg;
    logic                   zero_reg;
    logic                   res_act_reg;

    // output register
    logic        out_valid_reg;
    logic [15:0] out_data_reg;
    logic        out_act_reg;

    // RAM port
    logic                   ram_we;
    logic [AW-1:0]          ram_addr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    spv_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    spv_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (SAMPLE_DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign s_func   = func_t'(s_tuser);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_acc   = s_tvalid & s_tready;

    // ---------------- sample write path ----------------
    logic signed [31:0] wv_in;
    logic signed [31:0] wv_sat;
    logic [31:0]        waddr32;
    logic               waddr_ok;

    assign wv_in    = 32'(signed'(s_tdata[31:16]));
    assign wv_sat   = (wv_in > SMAX) ? 32'(SMAX) : ((wv_in < SMIN) ? 32'(SMIN) : wv_in);
    assign waddr32  = 32'(s_tdata[15:0]);
    assign waddr_ok = (waddr32 < 32'(SAMPLE_DEPTH));

    // ---------------- tick bookkeeping, from current voice state ----------------
    logic [31:0]         n32, ipart32, idx0_32, idx1_32;
    logic [32:0]         fprod;
    logic [16:0]         fade_c;
    logic [15:0]         rem_t;
    logic                act_t;
    logic [POS_BITS-1:0] pos_t;
    logic                zero_t;
    logic [63:0]         end_pos;
    logic                end_hit;
    logic [POS_BITS:0]   pos_sum;

    always_comb begin
        n32 = (cfg.sample_count == 17'd0) ? 32'd1 : 32'(cfg.sample_count);
        if (n32 > 32'(SAMPLE_DEPTH)) begin
            n32 = 32'(SAMPLE_DEPTH);
        end
        ipart32 = 32'(pos_reg >> FRAC_BITS);
        idx0_32 = (ipart32 > n32 - 32'd1) ? n32 - 32'd1 : ipart32;
        idx1_32 = (idx0_32 + 32'd1 < n32) ? idx0_32 + 32'd1 : idx0_32;
    end

    assign fprod   = rem_reg * cfg.release_recip;
    assign end_pos = 64'(cfg.stop_frame) << FRAC_BITS;
    assign end_hit = (64'(pos_reg) >= end_pos);
    assign pos_sum = {1'b0, pos_reg} + (POS_BITS+1)'(cfg.playback_step);

    always_comb begin
        fade_c = FADE_UNITY;
        rem_t  = rem_reg;
        act_t  = active_reg;
        pos_t  = pos_reg;
        zero_t = 1'b1;
        if (active_reg) begin
            if (releasing_reg) begin
                fade_c = (fprod[32:16] > FADE_UNITY) ? FADE_UNITY : fprod[32:16];
                if (rem_reg <= 16'd1) begin
                    rem_t = 16'd0;
                    act_t = 1'b0;
                end else begin
                    rem_t = rem_reg - 16'd1;
                end
            end
            if (end_hit) begin
                act_t = 1'b0;
            end else begin
                zero_t = 1'b0;
                pos_t  = pos_sum[POS_BITS] ? '1 : pos_sum[POS_BITS-1:0];
            end
        end
    end

    // ---------------- RAM port mux ----------------
    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = idx1_reg;
        ram_wdata = wv_sat[SAMPLE_BITS-1:0];
        if (in_acc) begin
            if (s_func == FN_WRITE) begin
                ram_we   = waddr_ok;
                ram_addr = waddr32[AW-1:0];
            end else begin
                ram_addr = idx0_32[AW-1:0];
            end
        end
    end

    // ---------------- datapath ----------------
    logic [32:0]          gprod;
    logic [FRAC_BITS:0]   w0;
    logic signed [MW-1:0] m0, m1;
    logic signed [PW-1:0] prod_next;

    assign gprod     = cfg.linear_gain * fade_reg;
    assign w0        = ONE_F - {1'b0, frac_reg};
    assign m0        = $signed(s0_reg) * $signed({1'b0, w0});
    assign m1        = $signed(ram_rdata) * $signed({2'b00, frac_reg});
    assign prod_next = mix_reg * $signed({1'b0, g_reg});

    // round half away from zero, saturate to 16 bits
    logic          neg;
    logic [PW-1:0] mag, rnd;
    logic [16:0]   mag17;
    logic [15:0]   rounded;

    always_comb begin
        neg   = prod_reg[PW-1];
        mag   = neg ? PW'(-prod_reg) : PW'(prod_reg);
        rnd   = (mag + HALF) >> SH;
        mag17 = (rnd > PW'(32768)) ? 17'd32768 : rnd[16:0];
        if (neg) begin
            rounded = 16'(17'd0 - mag17);
        end else if (mag17 == 17'd32768) begin
            rounded = 16'h7fff;
        end else begin
            rounded = mag17[15:0];
        end
    end

    // ---------------- sequencer ----------------
    logic out_load;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        out_load   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_acc && s_func == FN_TICK) begin
                    state_next = zero_t ? ST_OUT : ST_RD1;
                end
            end
            ST_RD1:  state_next = ST_RD2;
            ST_RD2:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_OUT;
            ST_OUT: begin
                if (!out_valid_reg || m_tready) begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // voice state updates
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg       <= POS_BITS'(RST_START_POS);
            active_reg    <= 1'b1;
            releasing_reg <= 1'b0;
            rem_reg       <= 16'd0;
        end else if (in_acc) begin
            case (s_func)
                FN_TICK: begin
                    pos_reg    <= pos_t;
                    active_reg <= act_t;
                    rem_reg    <= rem_t;
                end
                FN_RELEASE: begin
                    if (!releasing_reg) begin
                        releasing_reg <= 1'b1;
                        rem_reg       <= cfg.release_length;
                    end
                end
                FN_RESTART: begin
                    pos_reg       <= POS_BITS'(cfg.play_start);
                    active_reg    <= 1'b1;
                    releasing_reg <= 1'b0;
                    rem_reg       <= 16'd0;
                end
                default: ;
            endcase
        end
    end

    // per-tick work registers
    always_ff @(posedge aclk) begin
        if (in_acc && s_func == FN_TICK) begin
            idx1_reg    <= idx1_32[AW-1:0];
            frac_reg    <= pos_reg[FRAC_BITS-1:0];
            fade_reg    <= fade_c;
            zero_reg    <= zero_t;
            res_act_reg <= act_t;
        end
        if (state_reg == ST_RD1) begin
            s0_reg <= ram_rdata;
            g_reg  <= gprod[31:16];
        end
        if (state_reg == ST_RD2) begin
            mix_reg <= m0 + m1;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= prod_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= zero_reg ? 16'd0 : rounded;
            out_act_reg  <= res_act_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_act_reg;

`ifndef SYNTH
    a_silent_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (!active_reg && !(in_acc && s_func == FN_RESTART)) |=> !active_reg)
        else $error("silent voice woke without restart");

    a_release_once: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_acc && s_func == FN_RELEASE && releasing_reg) |=> $stable(rem_reg))
        else $error("repeated release reloaded the fade count");

    a_pos_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_acc && s_func == FN_RESTART) |=> (pos_reg >= $past(pos_reg)))
        else $error("read position moved backward");

    a_result_waits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_valid_reg && !m_tready) |=> state_reg == ST_OUT)
        else $error("tick result left while output register was full");
`endif

endmodule

[rtl/spv_ram.sv]
// Generic single-port RAM with registered read data.
// No dependencies.
module spv_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/spv_regs.sv]
// APB-style configuration register file of the voice.
// Depends on spv_pkg (cfg_t, register indexes, reset values).
module spv_regs
    import spv_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [CFG_ADDR_BITS-1:0] paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,
    output cfg_t                     cfg
);

    cfg_t       cfg_reg;
    logic [2:0] idx;
    logic       wr;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];
    assign wr     = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.play_start     <= RST_START_POS;
            cfg_reg.stop_frame     <= RST_STOP_FRAME;
            cfg_reg.sample_count   <= RST_COUNT;
            cfg_reg.playback_step  <= RST_STEP;
            cfg_reg.linear_gain    <= RST_GAIN;
            cfg_reg.release_length <= RST_REL_LEN;
            cfg_reg.release_recip  <= RST_REL_RECIP;
        end else if (wr) begin
            unique case (idx)
                REG_START_POS:  cfg_reg.play_start     <= pwdata;
                REG_STOP_FRAME: cfg_reg.stop_frame     <= pwdata[16:0];
                REG_COUNT:      cfg_reg.sample_count   <= pwdata[16:0];
                REG_STEP:       cfg_reg.playback_step  <= pwdata[23:0];
                REG_GAIN:       cfg_reg.linear_gain    <= pwdata[15:0];
                REG_REL_LEN:    cfg_reg.release_length <= pwdata[15:0];
                REG_REL_RECIP:  cfg_reg.release_recip  <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_START_POS:  prdata = cfg_reg.play_start;
            REG_STOP_FRAME: prdata = 32'(cfg_reg.stop_frame);
            REG_COUNT:      prdata = 32'(cfg_reg.sample_count);
            REG_STEP:       prdata = 32'(cfg_reg.playback_step);
            REG_GAIN:       prdata = 32'(cfg_reg.linear_gain);
            REG_REL_LEN:    prdata = 32'(cfg_reg.release_length);
            REG_REL_RECIP:  prdata = 32'(cfg_reg.release_recip);
            default:        prdata = 32'd0;
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[tb/sample_playback_voice_interp_core_tb.sv]
`timescale 1ns / 100ps
// Testbench for sample_playback_voice_interp_core: directed and random command words,
// checked frame by frame against a behavioral model of the voice kept in a scoreboard.
// Depends on spv_pkg and the RTL of the voice.

import spv_pkg::*;

typedef struct {
    logic [15:0] sample_out;
    logic        voice_active;
} frame_t;

class voice_scoreboard;
    // register copies
    bit [31:0] play_start;
    bit [16:0] stop_frame;
    bit [16:0] sample_count;
    bit [23:0] playback_step;
    bit [15:0] linear_gain;
    bit [15:0] release_length;
    bit [16:0] release_recip;
    // voice state; only written samples exist in the store
    shortint   sample_store [int];
    longint    position;
    bit        sounding;
    bit        releasing;
    longint    fade_left;
    frame_t    frames_due [$];
    int        mismatches;
    int        frames_checked;

    function new();
        play_start     = RST_START_POS;
        stop_frame     = RST_STOP_FRAME;
        sample_count   = RST_COUNT;
        playback_step  = RST_STEP;
        linear_gain    = RST_GAIN;
        release_length = RST_REL_LEN;
        release_recip  = RST_REL_RECIP;
        position       = RST_START_POS;
        sounding       = 1'b1;
        releasing      = 1'b0;
        fade_left      = 0;
        mismatches     = 0;
        frames_checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, bit [31:0] value);
        case (idx)
            REG_START_POS:  play_start     = value;
            REG_STOP_FRAME: stop_frame     = value[16:0];
            REG_COUNT:      sample_count   = value[16:0];
            REG_STEP:       playback_step  = value[23:0];
            REG_GAIN:       linear_gain    = value[15:0];
            REG_REL_LEN:    release_length = value[15:0];
            REG_REL_RECIP:  release_recip  = value[16:0];
            default: ;
        endcase
    endfunction

    // Which two samples the next tick blends, if it renders at all.
    function bit next_reads(output int lo_idx, output int hi_idx);
        longint n;
        longint whole;
        lo_idx = 0;
        hi_idx = 0;
        if (!sounding || position >= (longint'(stop_frame) << 16))
            return 1'b0;
        n = (sample_count == 0) ? 1 : longint'(sample_count);
        if (n > 65536)
            n = 65536;
        whole  = position >> 16;
        lo_idx = int'((whole > n - 1) ? n - 1 : whole);
        hi_idx = int'((lo_idx + 1 < n) ? lo_idx + 1 : lo_idx);
        return 1'b1;
    endfunction

    function frame_t render_frame();
        frame_t fr;
        longint fade, gain_eff, frac, mix, prod, mag;
        int     lo_idx, hi_idx;
        bit     reads;
        fr.sample_out = 16'h0000;
        if (sounding) begin
            reads = next_reads(lo_idx, hi_idx);
            fade  = 65536;
            if (releasing) begin
                fade = (fade_left * longint'(release_recip)) >> 16;
                if (fade > 65536)
                    fade = 65536;
                // frame uses the count before it steps down
                if (fade_left <= 1) begin
                    fade_left = 0;
                    sounding  = 1'b0;
                end else begin
                    fade_left--;
                end
            end
            if (!reads) begin
                sounding = 1'b0;
            end else begin
                frac     = position & 65535;
                mix      = longint'(sample_store[lo_idx]) * (65536 - frac)
                         + longint'(sample_store[hi_idx]) * frac;
                gain_eff = (longint'(linear_gain) * fade) >> 16;
                prod     = mix * gain_eff;
                // round half away from zero, then saturate
                mag = (prod < 0) ? -prod : prod;
                mag = (mag + (longint'(1) << 27)) >> 28;
                if (mag > 32768)
                    mag = 32768;
                if (prod < 0)
                    mag = -mag;
                if (mag > 32767)
                    mag = 32767;
                fr.sample_out = mag[15:0];
                position += longint'(playback_step);
                if (position > (longint'(1) << 33) - 1)
                    position = (longint'(1) << 33) - 1;
            end
        end
        fr.voice_active = sounding;
        return fr;
    endfunction

    function void take_command(func_t f, bit [15:0] addr, bit [15:0] value);
        case (f)
            FN_WRITE:   sample_store[int'(addr)] = shortint'(value);
            FN_RELEASE: begin
                if (!releasing) begin
                    releasing = 1'b1;
                    fade_left = longint'(release_length);
                end
            end
            FN_RESTART: begin
                position  = longint'(play_start);
                sounding  = 1'b1;
                releasing = 1'b0;
                fade_left = 0;
            end
            default:    frames_due.push_back(render_frame());
        endcase
    endfunction

    function void check_frame(logic [15:0] got_sample, logic got_active);
        frame_t want;
        if (frames_due.size() == 0) begin
            $display("%0t: result word with none expected: sample_out %0d, voice_active %b",
                     $time, $signed(got_sample), got_active);
            mismatches++;
            return;
        end
        want = frames_due.pop_front();
        frames_checked++;
        if (got_sample !== want.sample_out) begin
            $display("%0t: sample_out mismatch: expected %0d (%h), actual %0d (%h)", $time,
                     $signed(want.sample_out), want.sample_out, $signed(got_sample), got_sample);
            mismatches++;
        end
        if (got_active !== want.voice_active) begin
            $display("%0t: voice_active mismatch: expected %b, actual %b",
                     $time, want.voice_active, got_active);
            mismatches++;
        end
    endfunction

    function int outstanding();
        return frames_due.size();
    endfunction
endclass

module sample_playback_voice_interp_core_tb;
    localparam int CLK_HALF       = 4;
    localparam int TARGET_WORDS   = 900;
    localparam int SETTLE_CYCLES  = 8;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 1000000;

    logic                     aclk = 1'b0;
    logic                     aresetn;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [31:0]              s_tdata;   // [15:0] address, [31:16] sample_value
    logic [1:0]               s_tuser;   // [1:0] func
    logic                     m_tvalid;
    logic                     m_tready;
    logic [15:0]              m_tdata;   // [15:0] sample_out
    logic [0:0]               m_tuser;   // [0] voice_active
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [CFG_ADDR_BITS-1:0] paddr;
    logic [31:0]              pwdata;
    logic [31:0]              prdata;
    logic                     pready;

    voice_scoreboard board;
    bit  squeeze_req;
    bit  no_gaps;
    int  words_sent;
    int  phases_run;
    int  cycle_count;

    sample_playback_voice_interp_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #(CLK_HALF) aclk = 1'b1;
        #(CLK_HALF) aclk = 1'b0;
    end

    // mostly short gaps, now and then a long one
    function automatic int draw_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic bit [15:0] draw_sample();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h7FFF;
        if (r == 1)
            return 16'h8000;
        if (r == 2)
            return 16'h0000;
        return 16'($urandom());
    endfunction

    // Offer one word, wait for the handshake, then maybe idle.
    task automatic send_word(func_t f, bit [15:0] addr, bit [15:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= f;
        s_tdata  <= {value, addr};
        do @(posedge aclk); while (s_tready !== 1'b1);
        board.take_command(f, addr, value);
        words_sent++;
        gap = no_gaps ? 0 : draw_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // A tick never reads a sample that was not stored: write the neighbors first if needed.
    task automatic send_tick();
        int lo_idx, hi_idx;
        if (board.next_reads(lo_idx, hi_idx)) begin
            if (!board.sample_store.exists(lo_idx))
                send_word(FN_WRITE, lo_idx[15:0], draw_sample());
            if (!board.sample_store.exists(hi_idx))
                send_word(FN_WRITE, hi_idx[15:0], draw_sample());
        end
        send_word(FN_TICK, 16'($urandom()), 16'($urandom()));
    endtask

    task automatic apb_write(logic [2:0] idx, bit [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (pready !== 1'b1);
        board.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // Quiet the stream and let every expected frame drain before touching registers.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (board.outstanding() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_config(bit [31:0] start, bit [16:0] endf, bit [16:0] count,
                               bit [23:0] step, bit [15:0] gain, bit [15:0] rlen,
                               bit [16:0] recip);
        settle();
        apb_write(REG_START_POS,  start);
        apb_write(REG_STOP_FRAME, {15'd0, endf});
        apb_write(REG_COUNT,      {15'd0, count});
        apb_write(REG_STEP,       {8'd0, step});
        apb_write(REG_GAIN,       {16'd0, gain});
        apb_write(REG_REL_LEN,    {16'd0, rlen});
        apb_write(REG_REL_RECIP,  {15'd0, recip});
        phases_run++;
        // new start position only takes effect on restart
        send_word(FN_RESTART, 16'($urandom()), 16'($urandom()));
    endtask

    // Settings biased so that most phases actually play for a while.
    task automatic draw_config();
        bit [31:0] start;
        bit [16:0] endf, count, recip;
        bit [23:0] step;
        bit [15:0] gain, rlen;
        int        r, back, c;
        r = $urandom_range(0, 9);
        endf = (r < 3) ? 17'd65536 : (r == 3) ? 17'd0 : 17'($urandom_range(1, 65536));
        r = $urandom_range(0, 19);
        back = $urandom_range(1, 48);
        if (r < 5)
            start = 32'd0;
        else if (r < 7)
            start = 32'hFFFF_FFFF;
        else if (int'(endf) > back)
            start = {16'(int'(endf) - back), 16'($urandom())};
        else
            start = {16'd0, 16'($urandom())};
        r = $urandom_range(0, 19);
        if (r < 3)
            step = 24'd0;
        else if (r < 5)
            step = 24'hFF_FFFF;
        else if (r < 8)
            step = 24'h01_0000;
        else
            step = 24'($urandom_range(1, 196608));
        r = $urandom_range(0, 9);
        if (r < 2) begin
            count = 17'd1;
        end else if (r < 4) begin
            count = 17'd65536;
        end else if (r < 8) begin
            // just past the start, so the upper neighbor gets clamped
            c = int'(start[31:16]) + $urandom_range(0, 6);
            if (c < 1)
                c = 1;
            if (c > 65536)
                c = 65536;
            count = 17'(c);
        end else begin
            count = 17'($urandom_range(1, 65536));
        end
        r = $urandom_range(0, 9);
        gain = (r == 0) ? 16'd0 : (r == 1) ? 16'hFFFF : (r < 4) ? 16'd4096 : 16'($urandom());
        r = $urandom_range(0, 9);
        rlen = (r < 2) ? 16'd1 : (r == 2) ? 16'hFFFF : 16'($urandom_range(2, 40));
        r = $urandom_range(0, 9);
        if (r == 0)
            recip = 17'd65536;
        else if (r == 1)
            recip = 17'd1;
        else if (r == 2)
            recip = 17'($urandom_range(1, 65536));
        else
            recip = 17'((65536 + int'(rlen) / 2) / int'(rlen));
        load_config(start, endf, count, step, gain, rlen, recip);
    endtask

    task automatic random_words(int count);
        int r;
        repeat (count) begin
            r = $urandom_range(0, 99);
            if (r < 72)
                send_tick();
            else if (r < 84)
                send_word(FN_WRITE, 16'($urandom()), draw_sample());
            else if (r < 93)
                send_word(FN_RELEASE, 16'($urandom()), 16'($urandom()));
            else
                send_word(FN_RESTART, 16'($urandom()), 16'($urandom()));
        end
    endtask

    // Result side: random stalls, free-running stretches, one long hold on request.
    initial begin : result_sink
        int r, free_run, hold;
        bit squeezed;
        free_run = 0;
        squeezed = 1'b0;
        m_tready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (squeeze_req && !squeezed) begin
                squeezed = 1'b1;
                m_tready <= 1'b0;
                for (hold = 0; hold < SQUEEZE_CYCLES; hold++)
                    @(posedge aclk);
            end else if (free_run > 0) begin
                free_run--;
                m_tready <= 1'b1;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    free_run = $urandom_range(30, 120);
                if (r < 70) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    repeat (draw_gap()) @(posedge aclk);
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn === 1'b1 && m_tvalid === 1'b1 && m_tready === 1'b1)
            board.check_frame(m_tdata, m_tuser[0]);
    end

    initial begin : watchdog
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge aclk);
        $display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        int chunk;
        board       = new();
        squeeze_req = 1'b0;
        no_gaps     = 1'b0;
        words_sent  = 0;
        phases_run  = 0;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= 32'd0;
        s_tuser  <= FN_WRITE;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= 32'd0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // reset settings: unity step and gain, full-scale samples at both ends
        send_word(FN_WRITE, 16'd0, 16'h7FFF);
        send_word(FN_WRITE, 16'd1, 16'h8000);
        send_word(FN_WRITE, 16'd2, 16'h0000);
        send_word(FN_WRITE, 16'd3, 16'hFFFF);
        repeat (3) send_tick();
        send_word(FN_RELEASE, 16'hFFFF, 16'hFFFF);
        send_word(FN_RELEASE, 16'h0000, 16'h0000);   // already releasing: no effect
        repeat (2) send_tick();

        // max gain saturates; one-frame fade, then release while silent and restart
        load_config(32'd0, 17'd65536, 17'd65536, 24'h01_0000, 16'hFFFF, 16'd1, 17'd65536);
        repeat (2) send_tick();
        send_word(FN_RELEASE, 16'd0, 16'd0);
        repeat (2) send_tick();
        send_word(FN_RELEASE, 16'd0, 16'd0);
        send_word(FN_RESTART, 16'd0, 16'd0);
        send_tick();

        // half-way positions land on rounding ties; last frame clamps the upper neighbor
        load_config(32'h0000_8000, 17'd65536, 17'd3, 24'h01_0000, 16'd4096, 16'd480, 17'd137);
        send_word(FN_WRITE, 16'd0, 16'h0001);
        send_word(FN_WRITE, 16'd1, 16'h0000);
        send_word(FN_WRITE, 16'd2, 16'hFFFF);
        repeat (3) send_tick();

        // end frame zero: silent from the first tick
        load_config(32'hFFFF_FFFF, 17'd0, 17'd1, 24'hFF_FFFF, 16'd0, 16'hFFFF, 17'd1);
        repeat (2) send_tick();

        while (words_sent < TARGET_WORDS) begin
            draw_config();
            no_gaps = ($urandom_range(0, 3) == 0);
            if (phases_run == 7) begin
                // receiver holds off while ticks keep coming, so the input backs up
                no_gaps     = 1'b1;
                squeeze_req = 1'b1;
                repeat (16) send_tick();
            end
            chunk = $urandom_range(30, 70);
            random_words(chunk);
        end

        settle();
        repeat (16) @(posedge aclk);
        $display("Sent %0d command words across %0d register settings; %0d frames checked.",
                 words_sent, phases_run, board.frames_checked);
        $display("Covered fades, end frames, restarts, saturation and a %0d-cycle output hold.",
                 SQUEEZE_CYCLES);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

[sim.f]
rtl/spv_pkg.sv
rtl/spv_ram.sv
rtl/spv_regs.sv
rtl/sample_playback_voice_interp_core.sv
tb/sample_playback_voice_interp_core_tb.sv
